// ----- hw/rtl/mbp_pkg.sv -----
// Package with the shared types and constants of the MSB-first bit packer.
`default_nettype none

package mbp_pkg;

    localparam int FIELD_WIDTH = 32;
    localparam int POS_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int OP_W        = 2;
    localparam int MAX_BYTES   = (FIELD_WIDTH + BYTE_W - 1) / BYTE_W;
    localparam int CNT_W       = $clog2(MAX_BYTES + 1);
    localparam int PACK_W      = FIELD_WIDTH + BYTE_W;
    localparam int DATA_W      = MAX_BYTES * BYTE_W;
    localparam int PEND_CNT_W  = $clog2(BYTE_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [FIELD_WIDTH-1:0] value;
        logic [LEN_W-1:0]       bit_count;
    } cmd_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  byte_index;
        logic              last;
    } pkt_word_t;

    // One queued job: completed bytes left-aligned, how many, first position.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic [POS_W-1:0]  index;
    } job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mbp_front.sv -----
// Front end: accepts commands, merges bits with the pending byte, queues jobs.
`default_nettype none

module mbp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire mbp_pkg::cmd_word_t cmd,
    input  wire logic              q_full,
    output logic                   push,
    output mbp_pkg::job_t          push_job
);
    import mbp_pkg::*;

    logic [BYTE_W-1:0]     pend_reg;
    logic [BYTE_W-1:0]     pend_next;
    logic [PEND_CNT_W-1:0] pc_reg;
    logic [PEND_CNT_W-1:0] pc_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;

    logic                  accept;
    logic                  len_ok;
    logic [LEN_W-1:0]      total;
    logic [CNT_W-1:0]      nbytes;
    logic [LEN_W-1:0]      shamt;
    logic [PACK_W-1:0]     vshift;
    logic [PACK_W-1:0]     merged;
    logic [MAX_BYTES:0][BYTE_W-1:0] merged_bytes;

    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !q_full;

    assign len_ok = (cmd.bit_count != '0) && (cmd.bit_count <= LEN_W'(FIELD_WIDTH));
    assign total  = LEN_W'(pc_reg) + cmd.bit_count;
    assign nbytes = total[PEND_CNT_W +: CNT_W];
    assign shamt  = LEN_W'(FIELD_WIDTH) - cmd.bit_count;

    // Shifting the value up drops its unused high bits; then it slides in
    // behind the pending bits, which sit left-aligned at the top.
    assign vshift       = {cmd.value, {BYTE_W{1'b0}}} << shamt;
    assign merged       = {pend_reg, {FIELD_WIDTH{1'b0}}} | (vshift >> pc_reg);
    assign merged_bytes = merged;

    always_comb
    begin
        pend_next      = pend_reg;
        pc_next        = pc_reg;
        pos_next       = pos_reg;
        push           = 1'b0;
        push_job.data  = merged[PACK_W-1:BYTE_W];
        push_job.count = nbytes;
        push_job.index = pos_reg;
        if (accept)
        begin
            case (cmd.op)
                OP_WRITE:
                begin
                    if (len_ok)
                    begin
                        pend_next = merged_bytes[CNT_W'(MAX_BYTES) - nbytes];
                        pc_next   = total[PEND_CNT_W-1:0];
                        pos_next  = pos_reg + POS_W'(nbytes);
                        push      = (nbytes != '0);
                    end
                end
                OP_FLUSH:
                begin
                    if (pc_reg != '0)
                    begin
                        push_job.data  = {pend_reg, {(DATA_W - BYTE_W){1'b0}}};
                        push_job.count = CNT_W'(1);
                        push           = 1'b1;
                        pos_next       = pos_reg + POS_W'(1);
                    end
                    pend_next = '0;
                    pc_next   = '0;
                end
                OP_RESTART:
                begin
                    pend_next = '0;
                    pc_next   = '0;
                    pos_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            pc_reg   <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            pc_reg   <= pc_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mbp_queue.sv -----
// Short job queue between the front end and the byte emitter.
`default_nettype none

module mbp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mbp_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output mbp_pkg::job_t      head
);
    import mbp_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] wr_next;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W-1:0] rd_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mbp_back.sv -----
// Back end: sends each queued job's bytes, one per cycle unless stalled.
`default_nettype none

module mbp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire mbp_pkg::job_t head,
    output logic               pop,
    output logic               pkt_valid,
    input  wire logic          pkt_stall,
    output mbp_pkg::pkt_word_t pkt
);
    import mbp_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  left_next;
    logic [POS_W-1:0]  idx_reg;
    logic [POS_W-1:0]  idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    pkt_word_t         out_word_reg;
    pkt_word_t         out_word_next;
    logic              load;

    // The output register takes a new word when it is empty or being drained.
    assign load = (!out_valid_reg || !pkt_stall) && (left_reg != '0);
    assign pop  = q_valid && ((left_reg == '0) || ((left_reg == CNT_W'(1)) && load));

    always_comb
    begin
        data_next = data_reg;
        left_next = left_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            data_next = head.data;
            left_next = head.count;
            idx_next  = head.index;
        end
        else if (load)
        begin
            data_next = data_reg << BYTE_W;
            left_next = left_reg - CNT_W'(1);
            idx_next  = idx_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next           = out_valid_reg;
        out_word_next            = out_word_reg;
        if (load)
        begin
            out_valid_next           = 1'b1;
            out_word_next.out_byte   = data_reg[DATA_W-1 -: BYTE_W];
            out_word_next.byte_index = idx_reg;
            out_word_next.last       = (left_reg == CNT_W'(1));
        end
        else if (!pkt_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign pkt_valid = out_valid_reg;
    assign pkt       = out_word_reg;

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        idx_reg      <= idx_next;
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/msb_first_bit_packer.sv -----
// Top level of the MSB-first variable-length bit packer.
//
// The command channel (cmd_valid, cmd_stall, cmd) takes one word per cycle
// unless cmd_stall is high: a write appends the low bit_count bits of value
// (1 to 32 bits, MSB first), a flush sends the pending bits left-aligned and
// zero-padded, and a restart clears the pending bits and the byte position.
// Other opcodes and writes with a length of zero or above 32 change nothing.
// The packet channel (pkt_valid, pkt_stall, pkt) returns each completed byte
// with its 16-bit stream position; last marks the final byte produced by one
// command word. A command that completes bytes is queued in the cycle it is
// accepted; its first byte passes through the queue slot, the back end's
// data register and the output register, and its bytes follow one per cycle
// while the receiver does not stall (up to four for a 32-bit write). The byte
// emitter sets that rate. The front end keeps accepting commands while the
// two-entry job queue has room; when the receiver stalls, the output
// register holds its word, the queue fills and cmd_stall rises. Reset clears
// the pending bits, the position, the queue and the output register.
`default_nettype none

module msb_first_bit_packer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire mbp_pkg::cmd_word_t cmd,
    output logic                    pkt_valid,
    input  wire logic               pkt_stall,
    output mbp_pkg::pkt_word_t      pkt
);
    import mbp_pkg::*;

    // Jobs flow front end -> queue -> back end; each side stalls on its own.
    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    logic q_valid;
    job_t head;

    mbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    mbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    mbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt)
    );

endmodule

`default_nettype wire

// ----- tb/sv/packed_byte_checker.sv -----
// Checker that predicts the byte stream of the MSB-first bit packer and compares it.
`timescale 1ns / 100ps

module packed_byte_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_stall,
    input  mbp_pkg::cmd_word_t cmd,
    input  logic               pkt_valid,
    input  logic               pkt_stall,
    input  mbp_pkg::pkt_word_t pkt,
    output int                 fail_count,
    output int                 backlog,
    output int                 bytes_checked
);
    import mbp_pkg::*;

    pkt_word_t        expected_bytes[$];
    pkt_word_t        oldest;
    logic [6:0]       held_bits;
    logic [2:0]       held_count;
    logic [POS_W-1:0] next_index;
    int               mismatches;
    int               checked;

    // Works out the bytes that one command word completes and queues them in order.
    task automatic pack_command(input cmd_word_t w);
        pkt_word_t   made [MAX_BYTES];
        int          made_n;
        logic [7:0]  acc;
        int          cnt;
        made_n = 0;
        acc    = {1'b0, held_bits};
        cnt    = held_count;
        case (w.op)
            OP_WRITE:
            begin
                if (w.bit_count != 0 && w.bit_count <= FIELD_WIDTH)
                begin
                    for (int i = int'(w.bit_count) - 1; i >= 0; i--)
                    begin
                        acc = {acc[6:0], w.value[i]};
                        cnt++;
                        if (cnt == BYTE_W)
                        begin
                            made[made_n] = {acc, next_index, 1'b0};
                            made_n++;
                            next_index++;
                            acc = '0;
                            cnt = 0;
                        end
                    end
                    held_bits  = acc[6:0];
                    held_count = 3'(cnt);
                end
            end
            OP_FLUSH:
            begin
                if (held_count != 0)
                begin
                    acc     = {1'b0, held_bits} << (BYTE_W - held_count);
                    made[0] = {acc, next_index, 1'b0};
                    made_n  = 1;
                    next_index++;
                end
                held_bits  = '0;
                held_count = '0;
            end
            OP_RESTART:
            begin
                held_bits  = '0;
                held_count = '0;
                next_index = '0;
            end
            default:
            begin
            end
        endcase
        for (int k = 0; k < made_n; k++)
        begin
            if (k == made_n - 1)
                made[k].last = 1'b1;
            expected_bytes.push_back(made[k]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            held_bits     = '0;
            held_count    = '0;
            next_index    = '0;
            mismatches    = 0;
            checked       = 0;
            fail_count    <= 0;
            backlog       <= 0;
            bytes_checked <= 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
                pack_command(cmd);
            if (pkt_valid && !pkt_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected word: out_byte %h, byte_index %0d, last %b",
                           pkt.out_byte, pkt.byte_index, pkt.last);
                    mismatches++;
                end
                else
                begin
                    oldest = expected_bytes.pop_front();
                    checked++;
                    if (pkt.out_byte !== oldest.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h", oldest.out_byte, pkt.out_byte);
                        mismatches++;
                    end
                    if (pkt.byte_index !== oldest.byte_index)
                    begin
                        $error("byte_index: expected %0d, actual %0d",
                               oldest.byte_index, pkt.byte_index);
                        mismatches++;
                    end
                    if (pkt.last !== oldest.last)
                    begin
                        $error("last: expected %b, actual %b", oldest.last, pkt.last);
                        mismatches++;
                    end
                end
            end
            fail_count    <= mismatches;
            backlog       <= expected_bytes.size();
            bytes_checked <= checked;
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the testbench for the MSB-first bit packer: stimulus, idling and verdict.
`timescale 1ns / 100ps

module testbench;

    import mbp_pkg::*;

    // The opcode that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // The receiver's long hold, in cycles, used to fill the job queue.
    localparam int HOLD_CYCLES    = 80;
    // Cycles without any word accepted on either channel before giving up.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles at the end, so that a stray byte would still be seen.
    localparam int TAIL_CYCLES    = 12;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd       = '0;
    logic      pkt_valid;
    logic      pkt_stall = 1'b0;
    pkt_word_t pkt;

    int fail_count;
    int backlog;
    int bytes_checked;

    // Sender and receiver idling controls. A quiet side draws no random idle gaps.
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit rx_hold_req = 1'b0;
    int stall_left  = 0;

    int n_write   = 0;
    int n_flush   = 0;
    int n_restart = 0;
    int n_ignored = 0;

    int idle_cycles = 0;

    always #1 clk = ~clk;

    msb_first_bit_packer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt)
    );

    packed_byte_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .pkt_valid     (pkt_valid),
        .pkt_stall     (pkt_stall),
        .pkt           (pkt),
        .fail_count    (fail_count),
        .backlog       (backlog),
        .bytes_checked (bytes_checked)
    );

    // Idle lengths: mostly none, often a few cycles, now and then a long stretch.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic cmd_word_t cmd_of(input logic [OP_W-1:0] op,
                                         input logic [FIELD_WIDTH-1:0] value,
                                         input logic [LEN_W-1:0] count);
        cmd_word_t w;
        w.op        = op;
        w.value     = value;
        w.bit_count = count;
        return w;
    endfunction

    // A word changes the block's state only if it is a write of 1 to 32 bits,
    // a flush or a restart. Everything else is passed over by the block.
    function automatic bit has_effect(input cmd_word_t w);
        case (w.op)
            OP_WRITE:
                return w.bit_count != 0 && w.bit_count <= FIELD_WIDTH;
            OP_FLUSH, OP_RESTART:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Random traffic is mostly writes of random length and content, with a
    // bias toward full-width writes. Flushes and restarts are sprinkled in,
    // and a few words are noise: zero or oversized lengths and the unused
    // opcode. The value field always carries random bits above the length,
    // so the block must mask them off.
    function automatic cmd_word_t random_cmd();
        int               r;
        logic [LEN_W-1:0] count;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 6) == 0)
            count = LEN_W'(FIELD_WIDTH);
        else
            count = LEN_W'($urandom_range(1, FIELD_WIDTH));
        if (r < 76)
            return cmd_of(OP_WRITE, $urandom(), count);
        if (r < 80)
            return cmd_of(OP_WRITE, $urandom(), ($urandom_range(0, 1) == 0) ? LEN_W'(0) :
                          LEN_W'($urandom_range(FIELD_WIDTH + 1, (1 << LEN_W) - 1)));
        if (r < 91)
            return cmd_of(OP_FLUSH, $urandom(), LEN_W'($urandom()));
        if (r < 96)
            return cmd_of(OP_RESTART, $urandom(), LEN_W'($urandom()));
        return cmd_of(OP_UNUSED, $urandom(), LEN_W'($urandom()));
    endfunction

    // Offers one word and holds it until the block takes it. Valid stays high
    // into the next word when there is no gap, so it is never dropped and
    // raised in the same time step.
    task automatic send_word(input cmd_word_t w);
        int gap;
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (!has_effect(w))
            n_ignored++;
        else
        begin
            case (w.op)
                OP_WRITE:
                    n_write++;
                OP_FLUSH:
                    n_flush++;
                default:
                    n_restart++;
            endcase
        end
        gap = tx_quiet ? 0 : gap_len();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Stops offering words until every predicted byte has come out. The
    // checker's backlog is registered, so the task waits on the clock before reading it.
    task automatic drain_outputs();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
    endtask

    // Runs random words until the given number of them had an effect on the
    // block; ignored words do not count. The sender's quiet mode flips now
    // and then, so there are stretches of back-to-back words.
    task automatic run_random(input int count);
        int        done;
        cmd_word_t w;
        done = 0;
        while (done < count)
        begin
            w = random_cmd();
            if ($urandom_range(0, 31) == 0)
                tx_quiet = !tx_quiet;
            send_word(w);
            if (has_effect(w))
                done++;
        end
    endtask

    // Receiver: stalls of random length, long holds on request, and quiet
    // stretches in which it takes a word every cycle.
    always @(posedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_req = 1'b0;
            stall_left  = HOLD_CYCLES - 1;
            pkt_stall   <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            pkt_stall <= 1'b1;
        end
        else
        begin
            stall_left = rx_quiet ? 0 : gap_len();
            if (stall_left == 0)
                pkt_stall <= 1'b0;
            else
            begin
                stall_left--;
                pkt_stall <= 1'b1;
            end
        end
        if ($urandom_range(0, 63) == 0)
            rx_quiet = !rx_quiet;
    end

    // Watchdog: a hang shows up as a long run of cycles with nothing accepted.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (pkt_valid && !pkt_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no word accepted for %0d cycles.", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words. A single bit with junk above it, then seven more to
        // complete the first byte.
        send_word(cmd_of(OP_WRITE, 32'hFFFF_FFFF, 6'd1));
        send_word(cmd_of(OP_WRITE, 32'hFFFF_FF55, 6'd7));
        // Full-width writes at the value extremes, each leaving no bits pending, so
        // the bytes line up with the field boundaries.
        send_word(cmd_of(OP_WRITE, 32'hFFFF_FFFF, 6'd32));
        send_word(cmd_of(OP_WRITE, 32'h0000_0000, 6'd32));
        send_word(cmd_of(OP_WRITE, 32'h8000_0001, 6'd32));
        // Zero length and lengths above the field width must change nothing.
        send_word(cmd_of(OP_WRITE, 32'hFFFF_FFFF, 6'd0));
        send_word(cmd_of(OP_WRITE, 32'hFFFF_FFFF, 6'd33));
        send_word(cmd_of(OP_WRITE, 32'hFFFF_FFFF, 6'd63));
        // A short write completes no byte; the flush then pads it out.
        send_word(cmd_of(OP_WRITE, 32'h0000_0005, 6'd3));
        send_word(cmd_of(OP_FLUSH, 32'h0000_0000, 6'd0));
        // A flush with nothing pending makes no byte.
        send_word(cmd_of(OP_FLUSH, 32'hFFFF_FFFF, 6'd63));
        // The unused opcode looks like a byte-sized write but is ignored.
        send_word(cmd_of(OP_UNUSED, 32'hFFFF_FFFF, 6'd8));
        // A restart with bits pending drops them and sends the position to 0.
        send_word(cmd_of(OP_WRITE, 32'h0000_001F, 6'd5));
        send_word(cmd_of(OP_RESTART, 32'hFFFF_FFFF, 6'd32));
        send_word(cmd_of(OP_WRITE, 32'h0000_00A5, 6'd8));
        // Seven and then six pending bits plus long fields give four bytes per word.
        send_word(cmd_of(OP_WRITE, 32'h0000_007F, 6'd7));
        send_word(cmd_of(OP_WRITE, 32'h7FFF_FFFE, 6'd31));
        send_word(cmd_of(OP_WRITE, 32'hDEAD_BEEF, 6'd32));
        send_word(cmd_of(OP_WRITE, 32'h0000_0002, 6'd2));
        send_word(cmd_of(OP_WRITE, 32'h0000_003F, 6'd6));
        send_word(cmd_of(OP_FLUSH, 32'h0000_0000, 6'd0));
        send_word(cmd_of(OP_FLUSH, 32'h0000_0000, 6'd0));
        drain_outputs();

        run_random(80);

        // Back pressure: the receiver holds off for a long stretch while the
        // sender keeps offering full-width writes, so the job queue fills and
        // the block stalls its command channel. Then the sender waits for
        // every byte to come out.
        rx_hold_req = 1'b1;
        tx_quiet    = 1'b1;
        repeat (12)
            send_word(cmd_of(OP_WRITE, $urandom(), LEN_W'(FIELD_WIDTH)));
        tx_quiet = 1'b0;
        drain_outputs();

        run_random(80);

        drain_outputs();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Sent %0d words: %0d writes, %0d flushes, %0d restarts, %0d ignored.",
                 n_write + n_flush + n_restart + n_ignored, n_write, n_flush, n_restart,
                 n_ignored);
        $display("Checked %0d output bytes, across directed corner cases and a long hold.",
                 bytes_checked);
        if (fail_count + backlog == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
